>>> rtl/dtw_pkg.sv
// Shared types, register codes and constants of the depth-to-world rotation block.
package dtw_pkg;

    // Configuration port.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;

    localparam logic [CFG_IDX_W-1:0] CFG_FOCAL_RECIP_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FOCAL_RECIP_Y = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_COL    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_ROW    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DEPTH_SCALE   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_ROTATION_QUAT = 3'd5;

    // Register widths.
    localparam int RECIP_W  = 32;
    localparam int CENTER_W = 20;
    localparam int SCALE_W  = 32;
    localparam int QUAT_W   = 64;
    localparam int QC_W     = 16;

    // Reset values.
    localparam logic [RECIP_W-1:0]  RST_FOCAL_RECIP = 32'd7158278;
    localparam logic [CENTER_W-1:0] RST_CENTER_COL  = 20'd81920;
    localparam logic [CENTER_W-1:0] RST_CENTER_ROW  = 20'd61440;
    localparam logic [SCALE_W-1:0]  RST_DEPTH_SCALE = 32'd16777;
    localparam logic [QUAT_W-1:0]   RST_ROT_QUAT    = 64'd16384;

    // Deprojected point, signed Q24.16, saturated.
    localparam int PT_W = 40;
    localparam logic signed [PT_W-1:0] PT_MAX = {1'b0, {(PT_W-1){1'b1}}};
    localparam logic signed [PT_W-1:0] PT_MIN = {1'b1, {(PT_W-1){1'b0}}};

    // Result width.
    localparam int OUT_W = 32;

    typedef struct packed {
        logic [RECIP_W-1:0]  focal_recip_x;
        logic [RECIP_W-1:0]  focal_recip_y;
        logic [CENTER_W-1:0] center_col;
        logic [CENTER_W-1:0] center_row;
        logic [SCALE_W-1:0]  depth_scale;
        logic [QUAT_W-1:0]   rotation_quat;
    } t_cfg;

    // Member order matches the register layout: w in the low half-word.
    typedef struct packed {
        logic signed [QC_W-1:0] z;
        logic signed [QC_W-1:0] y;
        logic signed [QC_W-1:0] x;
        logic signed [QC_W-1:0] w;
    } t_quat;

    typedef struct packed {
        logic signed [PT_W-1:0] x;
        logic signed [PT_W-1:0] y;
        logic signed [PT_W-1:0] z;
    } t_point;

endpackage

>>> rtl/dtw_if.sv
// Channel interfaces: pixel input, world point output and configuration writes.
interface dtw_pixel_if #(
    parameter int COORD_BITS = 12,
    parameter int DEPTH_BITS = 16
);
    logic                  valid;
    logic                  ready;
    logic [COORD_BITS-1:0] pixel_col;
    logic [COORD_BITS-1:0] pixel_row;
    logic [DEPTH_BITS-1:0] raw_depth;

    modport source (output valid, output pixel_col, output pixel_row, output raw_depth,
                    input ready);
    modport sink (input valid, input pixel_col, input pixel_row, input raw_depth,
                  output ready);
endinterface

interface dtw_world_if;
    logic                               valid;
    logic                               ready;
    logic signed [dtw_pkg::OUT_W-1:0]   world_x;
    logic signed [dtw_pkg::OUT_W-1:0]   world_y;
    logic signed [dtw_pkg::OUT_W-1:0]   world_z;
    logic signed [dtw_pkg::OUT_W-1:0]   world_w;

    modport source (output valid, output world_x, output world_y, output world_z,
                    output world_w, input ready);
    modport sink (input valid, input world_x, input world_y, input world_z,
                  input world_w, output ready);
endinterface

interface dtw_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [dtw_pkg::CFG_IDX_W-1:0]    index;
    logic [dtw_pkg::CFG_DATA_W-1:0]   data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

>>> rtl/dtw_cfg_regs.sv
// Configuration register file with index decode.
module dtw_cfg_regs (
    input  logic          i_clk,
    input  logic          i_rst_n,
    dtw_cfg_if.sink       i_cfg,
    output dtw_pkg::t_cfg o_cfg
);

    dtw_pkg::t_cfg r_cfg;

    assign i_cfg.ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.focal_recip_x <= dtw_pkg::RST_FOCAL_RECIP;
            r_cfg.focal_recip_y <= dtw_pkg::RST_FOCAL_RECIP;
            r_cfg.center_col    <= dtw_pkg::RST_CENTER_COL;
            r_cfg.center_row    <= dtw_pkg::RST_CENTER_ROW;
            r_cfg.depth_scale   <= dtw_pkg::RST_DEPTH_SCALE;
            r_cfg.rotation_quat <= dtw_pkg::RST_ROT_QUAT;
        end else if (i_cfg.valid) begin
            // Writes to indexes beyond the register list are dropped.
            unique case (i_cfg.index)
                dtw_pkg::CFG_FOCAL_RECIP_X: begin
                    r_cfg.focal_recip_x <= i_cfg.data[dtw_pkg::RECIP_W-1:0];
                end
                dtw_pkg::CFG_FOCAL_RECIP_Y: begin
                    r_cfg.focal_recip_y <= i_cfg.data[dtw_pkg::RECIP_W-1:0];
                end
                dtw_pkg::CFG_CENTER_COL: begin
                    r_cfg.center_col <= i_cfg.data[dtw_pkg::CENTER_W-1:0];
                end
                dtw_pkg::CFG_CENTER_ROW: begin
                    r_cfg.center_row <= i_cfg.data[dtw_pkg::CENTER_W-1:0];
                end
                dtw_pkg::CFG_DEPTH_SCALE: begin
                    r_cfg.depth_scale <= i_cfg.data[dtw_pkg::SCALE_W-1:0];
                end
                dtw_pkg::CFG_ROTATION_QUAT: begin
                    r_cfg.rotation_quat <= i_cfg.data[dtw_pkg::QUAT_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

endmodule

>>> rtl/dtw_project.sv
// Seven-stage pipeline: depth scaling, pinhole deprojection and point saturation.
module dtw_project #(
    parameter int COORD_BITS = 12,
    parameter int DEPTH_BITS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  dtw_pkg::t_cfg         i_cfg,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [COORD_BITS-1:0] i_col,
    input  logic [COORD_BITS-1:0] i_row,
    input  logic [DEPTH_BITS-1:0] i_depth,
    output logic                  o_valid,
    input  logic                  i_ready,
    output dtw_pkg::t_point       o_point
);

    localparam int NST   = 7;
    localparam int SH_W  = COORD_BITS + 8;
    localparam int DU_W  = ((SH_W > dtw_pkg::CENTER_W) ? SH_W : dtw_pkg::CENTER_W) + 1;
    localparam int UP_W  = DU_W + dtw_pkg::RECIP_W + 1;
    localparam int U_W   = UP_W - 24;
    localparam int DP_W  = DEPTH_BITS + dtw_pkg::SCALE_W;
    localparam int D_W   = DP_W - 8;
    localparam int DL_W  = (D_W + 1) / 2;
    localparam int DH_W  = D_W - DL_W;
    localparam int LO_W  = U_W + DL_W;
    localparam int HI_W  = U_W + DH_W;
    localparam int P_W   = U_W + D_W + 1;
    localparam int R_W   = P_W - 16;
    localparam int ZX_W  = (D_W > dtw_pkg::PT_W) ? D_W : dtw_pkg::PT_W;

    localparam logic signed [UP_W-1:0] U_RND = UP_W'(24'h800000);
    localparam logic [P_W-1:0]         P_RND = P_W'(16'h8000);
    localparam logic [DP_W-1:0]        D_RND = DP_W'(8'h80);

    // Rounded magnitude to signed Q24.16 with saturation.
    function automatic logic signed [dtw_pkg::PT_W-1:0] sat_point(
        input logic           neg,
        input logic [R_W-1:0] mag
    );
        logic                          ovf;
        logic signed [dtw_pkg::PT_W-1:0] low;
        ovf = |mag[R_W-1:dtw_pkg::PT_W-1];
        low = $signed(mag[dtw_pkg::PT_W-1:0]);
        if (ovf) begin
            sat_point = neg ? dtw_pkg::PT_MIN : dtw_pkg::PT_MAX;
        end else begin
            sat_point = neg ? -low : low;
        end
    endfunction

    logic [NST-1:0] r_vld;
    wire  [NST-1:0] w_adv;

    genvar gk;
    generate
        for (gk = 0; gk < NST; gk++) begin : g_adv
            assign w_adv[gk] = i_ready || !(&r_vld[NST-1:gk]);
        end
    endgenerate

    assign o_ready = w_adv[0];
    assign o_valid = r_vld[NST-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= (r_vld & ~w_adv) | (w_adv & {r_vld[NST-2:0], i_valid});
        end
    end

    // Stage 0: raw depth product and principal point offsets.
    logic        [DP_W-1:0] w_dprod;
    logic signed [DU_W-1:0] w_du;
    logic signed [DU_W-1:0] w_dv;
    logic        [DP_W-1:0] r0_dprod;
    logic signed [DU_W-1:0] r0_du;
    logic signed [DU_W-1:0] r0_dv;

    assign w_dprod = i_depth * i_cfg.depth_scale;
    assign w_du = DU_W'($signed({1'b0, i_col, 8'h00}))
                - DU_W'($signed({1'b0, i_cfg.center_col}));
    assign w_dv = DU_W'($signed({1'b0, i_row, 8'h00}))
                - DU_W'($signed({1'b0, i_cfg.center_row}));

    always_ff @(posedge i_clk) begin
        if (w_adv[0]) begin
            r0_dprod <= w_dprod;
            r0_du    <= w_du;
            r0_dv    <= w_dv;
        end
    end

    // Stage 1: depth in Q.16 metres, offsets times reciprocal focal lengths.
    logic        [DP_W-1:0] w_dsum;
    logic signed [UP_W-1:0] w_up;
    logic signed [UP_W-1:0] w_vp;
    logic        [D_W-1:0]  r1_d;
    logic signed [UP_W-1:0] r1_up;
    logic signed [UP_W-1:0] r1_vp;

    assign w_dsum = r0_dprod + D_RND;
    assign w_up   = r0_du * $signed({1'b0, i_cfg.focal_recip_x});
    assign w_vp   = r0_dv * $signed({1'b0, i_cfg.focal_recip_y});

    always_ff @(posedge i_clk) begin
        if (w_adv[1]) begin
            r1_d  <= w_dsum[DP_W-1:8];
            r1_up <= w_up;
            r1_vp <= w_vp;
        end
    end

    // Stage 2: normalized image coordinates, rounded half up.
    logic        [UP_W-1:0] w_usum;
    logic        [UP_W-1:0] w_vsum;
    logic        [D_W-1:0]  r2_d;
    logic signed [U_W-1:0]  r2_u;
    logic signed [U_W-1:0]  r2_v;

    assign w_usum = r1_up + U_RND;
    assign w_vsum = r1_vp + U_RND;

    always_ff @(posedge i_clk) begin
        if (w_adv[2]) begin
            r2_d <= r1_d;
            r2_u <= $signed(w_usum[UP_W-1:24]);
            r2_v <= $signed(w_vsum[UP_W-1:24]);
        end
    end

    // Stage 3: sign and magnitude, so the depth product rounds away from zero.
    logic [D_W-1:0] r3_d;
    logic [U_W-1:0] r3_umag;
    logic [U_W-1:0] r3_vmag;
    logic           r3_uneg;
    logic           r3_vneg;

    always_ff @(posedge i_clk) begin
        if (w_adv[3]) begin
            r3_d    <= r2_d;
            r3_uneg <= r2_u[U_W-1];
            r3_vneg <= r2_v[U_W-1];
            r3_umag <= r2_u[U_W-1] ? $unsigned(-r2_u) : $unsigned(r2_u);
            r3_vmag <= r2_v[U_W-1] ? $unsigned(-r2_v) : $unsigned(r2_v);
        end
    end

    // Stage 4: the wide magnitude times depth product, split on the depth halves.
    logic [D_W-1:0]  r4_d;
    logic            r4_uneg;
    logic            r4_vneg;
    logic [LO_W-1:0] r4_ulo;
    logic [HI_W-1:0] r4_uhi;
    logic [LO_W-1:0] r4_vlo;
    logic [HI_W-1:0] r4_vhi;

    always_ff @(posedge i_clk) begin
        if (w_adv[4]) begin
            r4_d    <= r3_d;
            r4_uneg <= r3_uneg;
            r4_vneg <= r3_vneg;
            r4_ulo  <= r3_umag * r3_d[DL_W-1:0];
            r4_uhi  <= r3_umag * r3_d[D_W-1:DL_W];
            r4_vlo  <= r3_vmag * r3_d[DL_W-1:0];
            r4_vhi  <= r3_vmag * r3_d[D_W-1:DL_W];
        end
    end

    // Stage 5: merge partial products and round to Q.16.
    logic [P_W-1:0] w_ufull;
    logic [P_W-1:0] w_vfull;
    logic [D_W-1:0] r5_d;
    logic           r5_uneg;
    logic           r5_vneg;
    logic [R_W-1:0] r5_umag;
    logic [R_W-1:0] r5_vmag;

    assign w_ufull = P_W'({r4_uhi, {DL_W{1'b0}}}) + P_W'(r4_ulo) + P_RND;
    assign w_vfull = P_W'({r4_vhi, {DL_W{1'b0}}}) + P_W'(r4_vlo) + P_RND;

    always_ff @(posedge i_clk) begin
        if (w_adv[5]) begin
            r5_d    <= r4_d;
            r5_uneg <= r4_uneg;
            r5_vneg <= r4_vneg;
            r5_umag <= w_ufull[P_W-1:16];
            r5_vmag <= w_vfull[P_W-1:16];
        end
    end

    // Stage 6: restore signs and saturate the point to 40 bits.
    logic [ZX_W-1:0] w_dz;
    dtw_pkg::t_point r6_point;

    assign w_dz = ZX_W'(r5_d);

    always_ff @(posedge i_clk) begin
        if (w_adv[6]) begin
            r6_point.x <= sat_point(r5_uneg, r5_umag);
            r6_point.y <= sat_point(r5_vneg, r5_vmag);
            r6_point.z <= (|w_dz[ZX_W-1:dtw_pkg::PT_W-1]) ? dtw_pkg::PT_MAX
                        : $signed(w_dz[dtw_pkg::PT_W-1:0]);
        end
    end

    assign o_point = r6_point;

endmodule

>>> rtl/dtw_rotate.sv
// Five-stage pipeline: quaternion sandwich product q*p*conj(q) and output saturation.
module dtw_rotate (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  dtw_pkg::t_quat                    i_quat,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  dtw_pkg::t_point                   i_point,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic signed [dtw_pkg::OUT_W-1:0]  o_x,
    output logic signed [dtw_pkg::OUT_W-1:0]  o_y,
    output logic signed [dtw_pkg::OUT_W-1:0]  o_z,
    output logic signed [dtw_pkg::OUT_W-1:0]  o_w
);

    localparam int NST  = 5;
    localparam int P1_W = dtw_pkg::PT_W + dtw_pkg::QC_W;
    localparam int S1_W = P1_W + 2;
    localparam int M_W  = S1_W - 14;
    localparam int P2_W = M_W + dtw_pkg::QC_W;
    localparam int S2_W = P2_W + 2;
    localparam int R2_W = S2_W - 14;
    localparam int OW   = dtw_pkg::OUT_W;

    localparam logic signed [S1_W-1:0] M_RND = S1_W'(15'sh2000);
    localparam logic signed [S2_W-1:0] R_RND = S2_W'(15'sh2000);
    localparam logic signed [OW-1:0]   O_MAX = {1'b0, {(OW-1){1'b1}}};
    localparam logic signed [OW-1:0]   O_MIN = {1'b1, {(OW-1){1'b0}}};

    function automatic logic signed [OW-1:0] sat_out(input logic signed [R2_W-1:0] v);
        logic all_one;
        logic all_zero;
        all_one  = &v[R2_W-1:OW-1];
        all_zero = ~|v[R2_W-1:OW-1];
        if (all_one || all_zero) begin
            sat_out = $signed(v[OW-1:0]);
        end else begin
            sat_out = v[R2_W-1] ? O_MIN : O_MAX;
        end
    endfunction

    logic [NST-1:0] r_vld;
    wire  [NST-1:0] w_adv;

    genvar gk;
    generate
        for (gk = 0; gk < NST; gk++) begin : g_adv
            assign w_adv[gk] = i_ready || !(&r_vld[NST-1:gk]);
        end
    endgenerate

    assign o_ready = w_adv[0];
    assign o_valid = r_vld[NST-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= (r_vld & ~w_adv) | (w_adv & {r_vld[NST-2:0], i_valid});
        end
    end

    // Quaternion as w, x, y, z and the point as x, y, z.
    logic signed [dtw_pkg::QC_W-1:0] w_q  [4];
    logic signed [dtw_pkg::PT_W-1:0] w_pt [3];

    always_comb begin
        w_q[0]  = i_quat.w;
        w_q[1]  = i_quat.x;
        w_q[2]  = i_quat.y;
        w_q[3]  = i_quat.z;
        w_pt[0] = i_point.x;
        w_pt[1] = i_point.y;
        w_pt[2] = i_point.z;
    end

    // Stage 0: every quaternion component times every point component.
    logic signed [P1_W-1:0] r0_p [4][3];

    genvar gj, gi;
    generate
        for (gj = 0; gj < 4; gj++) begin : g_p1_q
            for (gi = 0; gi < 3; gi++) begin : g_p1_pt
                always_ff @(posedge i_clk) begin
                    if (w_adv[0]) begin
                        r0_p[gj][gi] <= w_q[gj] * w_pt[gi];
                    end
                end
            end
        end
    endgenerate

    // Stage 1: m = q*p with p = (0, x, y, z), rounded to Q.16.
    logic signed [S1_W-1:0] w_ms [4];
    logic signed [M_W-1:0]  r1_m [4];

    always_comb begin
        w_ms[0] = M_RND - (S1_W'(r0_p[1][0]) + S1_W'(r0_p[2][1]) + S1_W'(r0_p[3][2]));
        w_ms[1] = M_RND + S1_W'(r0_p[0][0]) + S1_W'(r0_p[2][2]) - S1_W'(r0_p[3][1]);
        w_ms[2] = M_RND + S1_W'(r0_p[0][1]) + S1_W'(r0_p[3][0]) - S1_W'(r0_p[1][2]);
        w_ms[3] = M_RND + S1_W'(r0_p[0][2]) + S1_W'(r0_p[1][1]) - S1_W'(r0_p[2][0]);
    end

    generate
        for (gj = 0; gj < 4; gj++) begin : g_m
            always_ff @(posedge i_clk) begin
                if (w_adv[1]) begin
                    r1_m[gj] <= $signed(w_ms[gj][S1_W-1:14]);
                end
            end
        end
    endgenerate

    // Stage 2: every component of m times every quaternion component.
    logic signed [P2_W-1:0] r2_p [4][4];

    generate
        for (gj = 0; gj < 4; gj++) begin : g_p2_m
            for (gi = 0; gi < 4; gi++) begin : g_p2_q
                always_ff @(posedge i_clk) begin
                    if (w_adv[2]) begin
                        r2_p[gj][gi] <= r1_m[gj] * w_q[gi];
                    end
                end
            end
        end
    endgenerate

    // Stage 3: r = m*conj(q), rounded to Q.16.
    logic signed [S2_W-1:0] w_rs [4];
    logic signed [R2_W-1:0] r3_r [4];

    always_comb begin
        w_rs[0] = R_RND + S2_W'(r2_p[0][0]) + S2_W'(r2_p[1][1])
                + S2_W'(r2_p[2][2]) + S2_W'(r2_p[3][3]);
        w_rs[1] = R_RND - S2_W'(r2_p[0][1]) + S2_W'(r2_p[1][0])
                - S2_W'(r2_p[2][3]) + S2_W'(r2_p[3][2]);
        w_rs[2] = R_RND - S2_W'(r2_p[0][2]) + S2_W'(r2_p[1][3])
                + S2_W'(r2_p[2][0]) - S2_W'(r2_p[3][1]);
        w_rs[3] = R_RND - S2_W'(r2_p[0][3]) - S2_W'(r2_p[1][2])
                + S2_W'(r2_p[2][1]) + S2_W'(r2_p[3][0]);
    end

    generate
        for (gj = 0; gj < 4; gj++) begin : g_r
            always_ff @(posedge i_clk) begin
                if (w_adv[3]) begin
                    r3_r[gj] <= $signed(w_rs[gj][S2_W-1:14]);
                end
            end
        end
    endgenerate

    // Stage 4: output register, saturated to 32 bits.
    logic signed [OW-1:0] r4_x;
    logic signed [OW-1:0] r4_y;
    logic signed [OW-1:0] r4_z;
    logic signed [OW-1:0] r4_w;

    always_ff @(posedge i_clk) begin
        if (w_adv[4]) begin
            r4_w <= sat_out(r3_r[0]);
            r4_x <= sat_out(r3_r[1]);
            r4_y <= sat_out(r3_r[2]);
            r4_z <= sat_out(r3_r[3]);
        end
    end

    assign o_x = r4_x;
    assign o_y = r4_y;
    assign o_z = r4_z;
    assign o_w = r4_w;

endmodule

>>> rtl/depth_to_world_rotate_top.sv
// Top level of the depth-to-world rotation block.
//
//  Channel  | Direction | Handshake     | Payload
//  ---------+-----------+---------------+-------------------------------------------
//  i_pix    | in        | valid / ready | pixel_col, pixel_row, raw_depth
//  o_world  | out       | valid / ready | world_x, world_y, world_z, world_w (Q16.16)
//  i_cfg    | in        | valid / ready | index, data (register write)
//
// One pixel is accepted per cycle unless the output stalls with every stage occupied; its
// result passes the seven deprojection stages and the five rotation stages including the output register.
// Reset is synchronous and active low; it empties the pipeline and restores the
// register defaults. The configuration port is always ready.
// A stall at the output holds each occupied stage; empty stages keep filling, so
// bubbles close up and nothing is dropped or repeated.
module depth_to_world_rotate_top #(
    parameter int COORD_BITS = 12,
    parameter int DEPTH_BITS = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    dtw_pixel_if.sink     i_pix,
    dtw_world_if.source   o_world,
    dtw_cfg_if.sink       i_cfg
);

    dtw_pkg::t_cfg   w_cfg;
    dtw_pkg::t_quat  w_quat;
    dtw_pkg::t_point w_point;
    logic            w_pt_valid;
    logic            w_pt_ready;

    assign w_quat = dtw_pkg::t_quat'(w_cfg.rotation_quat);

    dtw_cfg_regs u_cfg_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (w_cfg)
    );

    dtw_project #(
        .COORD_BITS (COORD_BITS),
        .DEPTH_BITS (DEPTH_BITS)
    ) u_project (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (w_cfg),
        .i_valid (i_pix.valid),
        .o_ready (i_pix.ready),
        .i_col   (i_pix.pixel_col),
        .i_row   (i_pix.pixel_row),
        .i_depth (i_pix.raw_depth),
        .o_valid (w_pt_valid),
        .i_ready (w_pt_ready),
        .o_point (w_point)
    );

    dtw_rotate u_rotate (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_quat  (w_quat),
        .i_valid (w_pt_valid),
        .o_ready (w_pt_ready),
        .i_point (w_point),
        .o_valid (o_world.valid),
        .i_ready (o_world.ready),
        .o_x     (o_world.world_x),
        .o_y     (o_world.world_y),
        .o_z     (o_world.world_z),
        .o_w     (o_world.world_w)
    );

endmodule

>>> rtl/dtw_checker.sv
// Port-level assertions for the depth-to-world rotation block and their binding.
module dtw_port_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_ready,
    input logic                          i_out_valid,
    input logic                          i_out_ready,
    input logic [dtw_pkg::OUT_W-1:0]     i_x,
    input logic [dtw_pkg::OUT_W-1:0]     i_y,
    input logic [dtw_pkg::OUT_W-1:0]     i_z,
    input logic [dtw_pkg::OUT_W-1:0]     i_w
);

    // Reset flushes the pipeline, so no result may follow a reset cycle.
    a_reset_flush: assert property (@(posedge i_clk) !i_rst_n |=> !i_out_valid)
        else $error("result valid right after reset");

    // With the output register empty every stage can move, so input must be ready.
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid |-> i_in_ready)
        else $error("input stalled while the output register is empty");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result withdrawn before its transaction completed");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            $stable(i_x) && $stable(i_y) && $stable(i_z) && $stable(i_w))
        else $error("result changed while stalled");

endmodule

bind depth_to_world_rotate_top dtw_port_checker u_dtw_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_pix.ready),
    .i_out_valid (o_world.valid),
    .i_out_ready (o_world.ready),
    .i_x         (o_world.world_x),
    .i_y         (o_world.world_y),
    .i_z         (o_world.world_z),
    .i_w         (o_world.world_w)
);

>>> tb/dtw_checker.sv
// Scoreboard of the depth-to-world block: predicts every world point and checks the output.
module dtw_checker #(
    parameter int COORD_BITS = 12,
    parameter int DEPTH_BITS = 16
) (
    input  logic i_clk,
    input  logic i_rst_n,
    dtw_pixel_if i_pix,
    dtw_world_if i_world,
    dtw_cfg_if   i_cfg,
    output int   o_fail_count,
    output int   o_pending,
    output int   o_checked
);
    timeunit 1ns;
    timeprecision 1ps;
    import dtw_pkg::*;

    localparam longint OUT_MAX = 64'sd2147483647;
    localparam longint OUT_MIN = -64'sd2147483648;

    typedef struct packed {
        logic signed [OUT_W-1:0] x;
        logic signed [OUT_W-1:0] y;
        logic signed [OUT_W-1:0] z;
        logic signed [OUT_W-1:0] w;
    } t_world;

    t_cfg   settings;
    t_world world_queue[$];

    // Arithmetic shift right with ties rounded toward plus infinity.
    function automatic longint round_half_up(longint value, int shift);
        return (value + (longint'(1) << (shift - 1))) >>> shift;
    endfunction

    // Multiplies a Q.16 image coordinate by the depth, ties away from zero,
    // and clamps the product to the 40-bit point range.
    function automatic longint scale_by_depth(longint coord, logic [63:0] metres);
        logic [63:0] mag;
        logic [63:0] prod;
        mag = (coord < 0) ? -coord : coord;
        if (metres != 0 && mag > ((64'd1 << 62) / metres)) begin
            prod = 64'd1 << 40;
        end else begin
            prod = (mag * metres + 64'd32768) >> 16;
        end
        if (coord < 0) return (prod >= (64'd1 << 39)) ? longint'(PT_MIN) : -longint'(prod);
        return (prod > 64'(PT_MAX)) ? longint'(PT_MAX) : longint'(prod);
    endfunction

    function automatic logic signed [OUT_W-1:0] clamp_out(longint value);
        if (value > OUT_MAX) value = OUT_MAX;
        if (value < OUT_MIN) value = OUT_MIN;
        return value[OUT_W-1:0];
    endfunction

    function automatic t_world deproject_rotate(logic [COORD_BITS-1:0] col,
                                                logic [COORD_BITS-1:0] row,
                                                logic [DEPTH_BITS-1:0] raw);
        t_quat       q;
        logic [63:0] metres;
        longint      qw, qx, qy, qz;
        longint      u, v, px, py, pz;
        longint      mw, mx, my, mz;
        t_world      pt;
        q  = settings.rotation_quat;
        qw = q.w;
        qx = q.x;
        qy = q.y;
        qz = q.z;
        metres = (64'(raw) * 64'(settings.depth_scale) + 64'd128) >> 8;
        u = round_half_up((longint'({col, 8'h00}) - longint'(settings.center_col))
                          * longint'(settings.focal_recip_x), 24);
        v = round_half_up((longint'({row, 8'h00}) - longint'(settings.center_row))
                          * longint'(settings.focal_recip_y), 24);
        px = scale_by_depth(u, metres);
        py = scale_by_depth(v, metres);
        pz = (metres > 64'(PT_MAX)) ? longint'(PT_MAX) : longint'(metres);
        // First half of the sandwich product: m = q * (0, p).
        mw = round_half_up(-(qx * px + qy * py + qz * pz), 14);
        mx = round_half_up(qw * px + qy * pz - qz * py, 14);
        my = round_half_up(qw * py + qz * px - qx * pz, 14);
        mz = round_half_up(qw * pz + qx * py - qy * px, 14);
        // Second half: m times the conjugate of q.
        pt.x = clamp_out(round_half_up(-mw * qx + mx * qw - my * qz + mz * qy, 14));
        pt.y = clamp_out(round_half_up(-mw * qy + mx * qz + my * qw - mz * qx, 14));
        pt.z = clamp_out(round_half_up(-mw * qz - mx * qy + my * qx + mz * qw, 14));
        pt.w = clamp_out(round_half_up(mw * qw + mx * qx + my * qy + mz * qz, 14));
        return pt;
    endfunction

    function automatic int coord_differs(string name, logic signed [OUT_W-1:0] want,
                                         logic signed [OUT_W-1:0] got);
        if (got === want) return 0;
        $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, want, got);
        return 1;
    endfunction

    always @(posedge i_clk) begin
        t_world want;
        int     bad;
        if (!i_rst_n) begin
            settings.focal_recip_x = RST_FOCAL_RECIP;
            settings.focal_recip_y = RST_FOCAL_RECIP;
            settings.center_col    = RST_CENTER_COL;
            settings.center_row    = RST_CENTER_ROW;
            settings.depth_scale   = RST_DEPTH_SCALE;
            settings.rotation_quat = RST_ROT_QUAT;
            world_queue.delete();
            o_fail_count = 0;
            o_checked    = 0;
        end else begin
            if (i_world.valid && i_world.ready) begin
                if (world_queue.size() == 0) begin
                    $display("%0t: unexpected world point x=%0d y=%0d z=%0d w=%0d", $time,
                             i_world.world_x, i_world.world_y, i_world.world_z,
                             i_world.world_w);
                    o_fail_count++;
                end else begin
                    want = world_queue.pop_front();
                    bad = coord_differs("world_x", want.x, i_world.world_x)
                        + coord_differs("world_y", want.y, i_world.world_y)
                        + coord_differs("world_z", want.z, i_world.world_z)
                        + coord_differs("world_w", want.w, i_world.world_w);
                    if (bad != 0) o_fail_count++;
                    o_checked++;
                end
            end
            // The prediction uses the settings in force before this edge's write.
            if (i_pix.valid && i_pix.ready) begin
                world_queue.push_back(deproject_rotate(i_pix.pixel_col, i_pix.pixel_row,
                                                       i_pix.raw_depth));
            end
            if (i_cfg.valid && i_cfg.ready) begin
                case (i_cfg.index)
                    CFG_FOCAL_RECIP_X: settings.focal_recip_x = i_cfg.data[RECIP_W-1:0];
                    CFG_FOCAL_RECIP_Y: settings.focal_recip_y = i_cfg.data[RECIP_W-1:0];
                    CFG_CENTER_COL:    settings.center_col    = i_cfg.data[CENTER_W-1:0];
                    CFG_CENTER_ROW:    settings.center_row    = i_cfg.data[CENTER_W-1:0];
                    CFG_DEPTH_SCALE:   settings.depth_scale   = i_cfg.data[SCALE_W-1:0];
                    CFG_ROTATION_QUAT: settings.rotation_quat = i_cfg.data[QUAT_W-1:0];
                    default: ;
                endcase
            end
        end
        o_pending = world_queue.size();
    end

endmodule

>>> tb/testbench.sv
// Top of the depth-to-world testbench: clock, reset, pixel and register stimulus, verdict.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import dtw_pkg::*;

    localparam int COORD_BITS       = 12;
    localparam int DEPTH_BITS       = 16;
    localparam int COORD_MAX        = (1 << COORD_BITS) - 1;
    localparam int DEPTH_MAX        = (1 << DEPTH_BITS) - 1;
    localparam int RANDOM_PER_PHASE = 280;
    localparam int TAIL_CYCLES      = 16;
    // Indexes that select no register; writes to them must change nothing.
    localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED_HI = 3'd7;

    logic clk = 1'b0;
    logic rst_n;
    int   idle_pct = 0;
    int   stall_pct = 0;
    int   fail_count;
    int   pending;
    int   checked;
    int   pixels_sent = 0;
    int   reg_writes = 0;

    dtw_pixel_if #(.COORD_BITS(COORD_BITS), .DEPTH_BITS(DEPTH_BITS)) pix_ch ();
    dtw_world_if world_ch ();
    dtw_cfg_if   cfg_ch ();

    depth_to_world_rotate_top #(
        .COORD_BITS(COORD_BITS),
        .DEPTH_BITS(DEPTH_BITS)
    ) u_top (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_pix   (pix_ch),
        .o_world (world_ch),
        .i_cfg   (cfg_ch)
    );

    dtw_checker #(
        .COORD_BITS(COORD_BITS),
        .DEPTH_BITS(DEPTH_BITS)
    ) u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_pix        (pix_ch),
        .i_world      (world_ch),
        .i_cfg        (cfg_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    initial begin
        #10_000_000;
        $display("Mismatches found");
        $finish;
    end

    // Output back-pressure, redrawn every cycle.
    initial begin
        world_ch.ready <= 1'b0;
        forever begin
            @(posedge clk);
            world_ch.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    task automatic send_pixel(input logic [COORD_BITS-1:0] col,
                              input logic [COORD_BITS-1:0] row,
                              input logic [DEPTH_BITS-1:0] raw);
        while ($urandom_range(99) < idle_pct) begin
            pix_ch.valid <= 1'b0;
            @(posedge clk);
        end
        pix_ch.valid     <= 1'b1;
        pix_ch.pixel_col <= col;
        pix_ch.pixel_row <= row;
        pix_ch.raw_depth <= raw;
        @(posedge clk);
        while (!pix_ch.ready) @(posedge clk);
        pixels_sent++;
    endtask

    task automatic send_random_pixel();
        logic [COORD_BITS-1:0] col;
        logic [COORD_BITS-1:0] row;
        logic [DEPTH_BITS-1:0] raw;
        col = COORD_BITS'($urandom_range(COORD_MAX));
        row = COORD_BITS'($urandom_range(COORD_MAX));
        raw = DEPTH_BITS'($urandom_range(DEPTH_MAX));
        // Push some pixels to the image border and the ends of the depth range.
        case ($urandom_range(7))
            0: col = ($urandom_range(1) != 0) ? COORD_BITS'(COORD_MAX) : '0;
            1: row = ($urandom_range(1) != 0) ? COORD_BITS'(COORD_MAX) : '0;
            2: raw = ($urandom_range(1) != 0) ? DEPTH_BITS'(DEPTH_MAX) : '0;
            3: raw = DEPTH_BITS'($urandom_range(4095));
            default: ;
        endcase
        send_pixel(col, row, raw);
    endtask

    // The valid stays high across back-to-back writes and drops after the last one.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] index,
                             input logic [CFG_DATA_W-1:0] value, input bit last);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= index;
        cfg_ch.data  <= value;
        @(posedge clk);
        while (!cfg_ch.ready) @(posedge clk);
        if (last) cfg_ch.valid <= 1'b0;
        reg_writes++;
    endtask

    task automatic apply_settings(input t_cfg c);
        write_reg(CFG_FOCAL_RECIP_X, 64'(c.focal_recip_x), 1'b0);
        write_reg(CFG_FOCAL_RECIP_Y, 64'(c.focal_recip_y), 1'b0);
        write_reg(CFG_CENTER_COL, 64'(c.center_col), 1'b0);
        write_reg(CFG_CENTER_ROW, 64'(c.center_row), 1'b0);
        write_reg(CFG_DEPTH_SCALE, 64'(c.depth_scale), 1'b0);
        write_reg(CFG_ROTATION_QUAT, c.rotation_quat, 1'b1);
    endtask

    // Holds the sender until every predicted world point has come out.
    task automatic wait_drained();
        pix_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    function automatic t_cfg random_cfg();
        t_cfg c;
        real  part[4];
        real  norm;
        int   k;
        c.focal_recip_x = 32'hFFFF_FFFF / $urandom_range(4000, 100);
        c.focal_recip_y = 32'hFFFF_FFFF / $urandom_range(4000, 100);
        if ($urandom_range(3) == 0) c.focal_recip_x = $urandom();
        if ($urandom_range(3) == 0) c.focal_recip_y = $urandom();
        c.center_col = ($urandom_range(3) == 0) ? 20'($urandom())
                     : {12'($urandom_range(COORD_MAX)), 8'($urandom())};
        c.center_row = ($urandom_range(3) == 0) ? 20'($urandom())
                     : {12'($urandom_range(COORD_MAX)), 8'($urandom())};
        c.depth_scale = ($urandom_range(3) == 0) ? $urandom() : $urandom_range(1 << 17);
        case ($urandom_range(3))
            0: c.rotation_quat = {$urandom(), $urandom()};
            1: begin
                // Quarter turn about one axis.
                c.rotation_quat = 64'(16'sd11585);
                c.rotation_quat[16 * $urandom_range(3, 1) +: 16] =
                    ($urandom_range(1) != 0) ? 16'sd11585 : -16'sd11585;
            end
            default: begin
                norm = 0.0;
                for (k = 0; k < 4; k++) begin
                    part[k] = real'(int'($urandom_range(2000)) - 1000);
                    norm += part[k] * part[k];
                end
                norm = (norm > 0.0) ? $sqrt(norm) : 1.0;
                for (k = 0; k < 4; k++) begin
                    c.rotation_quat[16 * k +: 16] = 16'($rtoi(part[k] / norm * 16383.0));
                end
            end
        endcase
        return c;
    endfunction

    initial begin
        int phase;
        int n;
        pix_ch.valid     <= 1'b0;
        pix_ch.pixel_col <= '0;
        pix_ch.pixel_row <= '0;
        pix_ch.raw_depth <= '0;
        cfg_ch.valid     <= 1'b0;
        cfg_ch.index     <= '0;
        cfg_ch.data      <= '0;
        rst_n            <= 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Reset settings: image corners, near the principal point, depth extremes.
        send_pixel(0, 0, 0);
        send_pixel(COORD_MAX, COORD_MAX, DEPTH_MAX);
        send_pixel(0, COORD_MAX, DEPTH_MAX);
        send_pixel(COORD_MAX, 0, 1);
        send_pixel(320, 240, 1000);
        send_pixel(319, 241, DEPTH_MAX);
        send_pixel(12'hAAA, 12'h555, 16'h5555);
        send_pixel(12'h555, 12'hAAA, 16'hAAAA);
        repeat (200) send_random_pixel();

        // All-ones data on every register: wide bits are dropped and the point
        // saturates before the rotation.
        wait_drained();
        write_reg(CFG_FOCAL_RECIP_X, '1, 1'b0);
        write_reg(CFG_FOCAL_RECIP_Y, '1, 1'b0);
        write_reg(CFG_CENTER_COL, '1, 1'b0);
        write_reg(CFG_CENTER_ROW, '1, 1'b0);
        write_reg(CFG_DEPTH_SCALE, '1, 1'b0);
        write_reg(CFG_ROTATION_QUAT, '1, 1'b1);
        send_pixel(0, 0, DEPTH_MAX);
        send_pixel(COORD_MAX, COORD_MAX, DEPTH_MAX);
        send_pixel(0, 0, 1);
        send_pixel(2048, 2048, 16'h8000);

        // Largest and most negative non-unit quaternions.
        wait_drained();
        write_reg(CFG_ROTATION_QUAT, 64'h7FFF_7FFF_7FFF_7FFF, 1'b1);
        send_pixel(0, 0, DEPTH_MAX);
        send_pixel(COORD_MAX, 0, DEPTH_MAX);
        send_pixel(2048, 2048, 1);
        wait_drained();
        write_reg(CFG_ROTATION_QUAT, 64'h8000_8000_8000_8000, 1'b1);
        send_pixel(0, COORD_MAX, DEPTH_MAX);
        send_pixel(COORD_MAX, COORD_MAX, DEPTH_MAX);
        send_pixel(1, 1, 16'h00FF);

        wait_drained();
        apply_settings('0);
        send_pixel(0, 0, DEPTH_MAX);
        send_pixel(COORD_MAX, COORD_MAX, DEPTH_MAX);
        send_pixel(100, 3000, 1);

        // Random settings under each traffic pattern.
        for (phase = 0; phase < 4; phase++) begin
            wait_drained();
            write_reg(CFG_UNMAPPED_LO, {$urandom(), $urandom()}, 1'b0);
            write_reg(CFG_UNMAPPED_HI, {$urandom(), $urandom()}, 1'b0);
            apply_settings(random_cfg());
            case (phase)
                0: begin
                    idle_pct  = 0;
                    stall_pct = 0;
                end
                1: begin
                    idle_pct  = 84;
                    stall_pct = 0;
                end
                2: begin
                    idle_pct  = 0;
                    stall_pct = 84;
                end
                default: begin
                    idle_pct  = 30;
                    stall_pct = 30;
                end
            endcase
            for (n = 0; n < RANDOM_PER_PHASE; n++) begin
                send_random_pixel();
                if (n == RANDOM_PER_PHASE / 2) wait_drained();
            end
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        $display("Drove %0d pixels and %0d register writes: reset, all-ones, all-zero and",
                 pixels_sent, reg_writes);
        $display("four random settings; %0d world points checked under gaps and stalls.",
                 checked);
        if (fail_count == 0 && pending == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

>>> filelist.f
rtl/dtw_pkg.sv
rtl/dtw_if.sv
rtl/dtw_cfg_regs.sv
rtl/dtw_project.sv
rtl/dtw_rotate.sv
rtl/depth_to_world_rotate_top.sv
rtl/dtw_checker.sv
tb/dtw_checker.sv
tb/testbench.sv
